### hdl/sorted_cue_point_table_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted cue point table unit
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_CUE_POINT_TABLE_UNIT_MACROS_SVH
`define SORTED_CUE_POINT_TABLE_UNIT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define SCPT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define SCPT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/scpt_pkg.sv
// ----------------------------------------------------------------------------
// scpt_pkg
// Constants and codes of the sorted cue point table unit.
// ----------------------------------------------------------------------------
package scpt_pkg;

  localparam int TableSlots    = 1022;
  localparam int MaxCuePoints  = 1021;
  localparam int AddrW         = 10;
  localparam int CountW        = 10;

  localparam logic [31:0] PosClamp  = 32'hFFFF_FFFE;
  localparam logic [31:0] EmptySlot = 32'hFFFF_FFFF;
  localparam logic [31:0] FreedSlot = 32'hFFFF_FFFE;
  localparam logic [31:0] HashMul   = 32'hC2B0_C3CC;

  localparam logic [2:0] ActAdd      = 3'd0;
  localparam logic [2:0] ActDelNear  = 3'd1;
  localparam logic [2:0] ActDelExact = 3'd2;
  localparam logic [2:0] ActClear    = 3'd3;
  localparam logic [2:0] ActSeekFwd  = 3'd4;
  localparam logic [2:0] ActSeekBwd  = 3'd5;

  localparam logic [1:0] StatOk      = 2'd0;
  localparam logic [1:0] StatRefused = 2'd1;
  localparam logic [1:0] StatNone    = 2'd2;

  localparam logic RegWriteEnable  = 1'b0;
  localparam logic RegTablePresent = 1'b1;

endpackage

### hdl/sorted_cue_point_table_unit.sv
// ----------------------------------------------------------------------------
// sorted_cue_point_table_unit
// Sorted table of tape cue points with add, delete, clear and seek requests.
// ----------------------------------------------------------------------------
//
//  channel  dir  signals                     beat
//  s        in   s_tvalid s_tready s_tdata   one request (action, position)
//                s_tuser
//  m        out  m_tvalid m_tready m_tdata   one result per request
//                m_tuser
//  cfg      in   cfg_we cfg_index cfg_data   one register write
//
// One request at a time. A binary search alternates an address state and a
// compare state per halving, insert and delete move entries one slot at a time,
// and every change ends with a checksum pass over all 1022 slots through one
// shared multiplier, with a multiply state and a fold state per slot.
// Seeks and refused requests end without a checksum pass.
// After reset a clearing pass over all slots and a checksum pass run before the
// first request is taken.
// A stalled result beat holds the sequencer in its final state.
// ----------------------------------------------------------------------------
`include "sorted_cue_point_table_unit_macros.svh"

module sorted_cue_point_table_unit #(
  parameter int MAX_CUE_POINTS = scpt_pkg::MaxCuePoints
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] position
  input  logic [2:0]  s_tuser,   // [2:0] action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // [31:0] target_position, [41:32] entry_count,
                                 // [73:42] table_checksum, [79:74] zero
  output logic [1:0]  m_tuser,   // [1:0] status
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic        cfg_data
);

  localparam int AW = scpt_pkg::AddrW;
  localparam int CW = scpt_pkg::CountW;
  localparam logic [AW-1:0] LastAddr = AW'(scpt_pkg::TableSlots - 1);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_LCHK     = 5'd1;
  localparam logic [4:0] S_LCMP     = 5'd2;
  localparam logic [4:0] S_SEEK_RD  = 5'd3;
  localparam logic [4:0] S_SEEK_GET = 5'd4;
  localparam logic [4:0] S_INS_RD   = 5'd5;
  localparam logic [4:0] S_INS_CMP  = 5'd6;
  localparam logic [4:0] S_DEL_RD   = 5'd7;
  localparam logic [4:0] S_DEL_CMP  = 5'd8;
  localparam logic [4:0] S_SH_RD    = 5'd9;
  localparam logic [4:0] S_SH_WR    = 5'd10;
  localparam logic [4:0] S_CLR      = 5'd11;
  localparam logic [4:0] S_H_START  = 5'd12;
  localparam logic [4:0] S_H_MUL    = 5'd13;
  localparam logic [4:0] S_H_FOLD   = 5'd14;
  localparam logic [4:0] S_DONE     = 5'd15;

  logic [4:0]    state;
  logic          wr_en;
  logic          tbl_present;
  logic [2:0]    act;
  logic [31:0]   pos;
  logic [CW-1:0] count;
  logic [31:0]   csum;
  logic [31:0]   h;
  logic [63:0]   prod;
  logic [AW-1:0] idx;
  logic [AW-1:0] lo;
  logic [AW-1:0] hi;
  logic [AW-1:0] mid_r;
  logic [AW-1:0] nreg;
  logic          lfin;
  logic [31:0]   best;
  logic          have;
  logic [AW-1:0] pick;
  logic          emit;
  logic [1:0]    res_status;
  logic [31:0]   res_target;

  logic [31:0]   mem [scpt_pkg::TableSlots];
  logic [31:0]   rdata;
  logic          mem_we;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;
  logic [AW-1:0] raddr;

  logic [AW-1:0] mid;
  logic          more;
  logic [AW-1:0] n_found;
  logic          fwd;
  logic [31:0]   near_dist;
  logic [31:0]   fold;
  logic [31:0]   in_pos;
  logic [4:0]    start_state;

  assign mid     = AW'(({1'b0, lo} + {1'b0, hi}) >> 1);
  assign more    = ({1'b0, lo} + (AW+1)'(1)) < {1'b0, hi};
  assign n_found = lfin ? lo : mid_r;
  assign fwd     = (act == scpt_pkg::ActSeekFwd);
  assign near_dist = (rdata >= pos) ? (rdata - pos) : (pos - rdata);
  assign fold    = prod[31:0] ^ prod[63:32];
  assign in_pos  = (s_tdata < scpt_pkg::PosClamp) ? s_tdata : scpt_pkg::PosClamp;
  assign s_tready = (state == S_IDLE);

  // First state of a request; refused and unused requests go straight to the result.
  always_comb begin
    start_state = S_DONE;
    case (s_tuser)
      scpt_pkg::ActAdd: begin
        if (wr_en && tbl_present && (count < CW'(MAX_CUE_POINTS))) begin
          start_state = S_LCHK;
        end
      end
      scpt_pkg::ActDelNear: begin
        if (wr_en && (count != '0)) begin
          start_state = S_DEL_RD;
        end
      end
      scpt_pkg::ActDelExact: begin
        if (wr_en && (count != '0)) begin
          start_state = S_LCHK;
        end
      end
      scpt_pkg::ActClear: begin
        if (wr_en && (count != '0)) begin
          start_state = S_CLR;
        end
      end
      scpt_pkg::ActSeekFwd, scpt_pkg::ActSeekBwd: begin
        if (count != '0) begin
          start_state = S_LCHK;
        end
      end
      default: begin
      end
    endcase
  end

  // Memory port addresses are slot numbers minus one.
  always_comb begin
    mem_we = 1'b0;
    waddr  = idx;
    wdata  = scpt_pkg::EmptySlot;
    raddr  = idx;
    case (state)
      S_CLR: begin
        mem_we = 1'b1;
      end
      S_LCHK: begin
        raddr = more ? (mid - AW'(1)) : (lo - AW'(1));
      end
      S_SEEK_RD: begin
        raddr = fwd ? nreg : (nreg - AW'(2));
      end
      S_INS_RD: begin
        if (idx == '0) begin
          mem_we = 1'b1;
          waddr  = '0;
          wdata  = pos;
        end else begin
          raddr = idx - AW'(1);
        end
      end
      S_INS_CMP: begin
        mem_we = 1'b1;
        waddr  = idx;
        wdata  = (rdata < pos) ? pos : rdata;
      end
      S_DEL_RD: begin
        raddr = idx - AW'(1);
      end
      S_SH_RD: begin
        if (idx >= AW'(count)) begin
          mem_we = 1'b1;
          waddr  = AW'(count) - AW'(1);
          wdata  = scpt_pkg::FreedSlot;
        end
      end
      S_SH_WR: begin
        mem_we = 1'b1;
        waddr  = idx - AW'(1);
        wdata  = rdata;
      end
      S_H_START: begin
        raddr = '0;
      end
      S_H_FOLD: begin
        raddr = (idx == LastAddr) ? idx : (idx + AW'(1));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLR;
      idx         <= '0;
      emit        <= 1'b0;
      count       <= '0;
      wr_en       <= 1'b0;
      tbl_present <= 1'b0;
      m_tvalid    <= 1'b0;
      have        <= 1'b0;
      lfin        <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == scpt_pkg::RegWriteEnable) begin
          wr_en <= cfg_data;
        end else begin
          tbl_present <= cfg_data;
        end
      end
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            act        <= s_tuser;
            pos        <= in_pos;
            res_target <= '0;
            res_status <= (s_tuser inside {scpt_pkg::ActSeekFwd, scpt_pkg::ActSeekBwd}) ?
                          scpt_pkg::StatNone : scpt_pkg::StatRefused;
            emit       <= 1'b1;
            lo         <= AW'(1);
            hi         <= AW'(count) + AW'(1);
            idx        <= (s_tuser == scpt_pkg::ActClear) ? '0 : AW'(1);
            have       <= 1'b0;
            state      <= start_state;
          end
        end
        S_LCHK: begin
          mid_r <= mid;
          lfin  <= !more;
          state <= S_LCMP;
        end
        S_LCMP: begin
          if (!lfin && (pos > rdata)) begin
            lo    <= mid_r;
            state <= S_LCHK;
          end else if (!lfin && (pos < rdata)) begin
            hi    <= mid_r;
            state <= S_LCHK;
          end else begin
            nreg <= n_found;
            case (act)
              scpt_pkg::ActAdd: begin
                if ((count != '0) && (rdata == pos)) begin
                  state <= S_DONE;
                end else begin
                  idx   <= AW'(count);
                  state <= S_INS_RD;
                end
              end
              scpt_pkg::ActDelExact: begin
                if (rdata == pos) begin
                  idx   <= AW'(1);
                  state <= S_DEL_RD;
                end else begin
                  state <= S_DONE;
                end
              end
              default: begin
                if ((!fwd && (rdata < pos)) || (fwd && (rdata > pos))) begin
                  res_target <= rdata;
                  res_status <= scpt_pkg::StatOk;
                  state      <= S_DONE;
                end else if ((!fwd && (n_found > AW'(1))) ||
                             (fwd && (n_found < AW'(count)))) begin
                  state <= S_SEEK_RD;
                end else begin
                  state <= S_DONE;
                end
              end
            endcase
          end
        end
        S_SEEK_RD: begin
          state <= S_SEEK_GET;
        end
        S_SEEK_GET: begin
          res_target <= rdata;
          res_status <= scpt_pkg::StatOk;
          state      <= S_DONE;
        end
        S_INS_RD: begin
          if (idx == '0) begin
            count <= count + CW'(1);
            state <= S_H_START;
          end else begin
            state <= S_INS_CMP;
          end
        end
        S_INS_CMP: begin
          if (rdata < pos) begin
            count <= count + CW'(1);
            state <= S_H_START;
          end else begin
            idx   <= idx - AW'(1);
            state <= S_INS_RD;
          end
        end
        S_DEL_RD: begin
          if (idx > AW'(count)) begin
            idx   <= pick;
            state <= S_SH_RD;
          end else begin
            state <= S_DEL_CMP;
          end
        end
        S_DEL_CMP: begin
          if (have && (near_dist >= best)) begin
            idx   <= pick;
            state <= S_SH_RD;
          end else begin
            best  <= near_dist;
            have  <= 1'b1;
            pick  <= idx;
            idx   <= idx + AW'(1);
            state <= S_DEL_RD;
          end
        end
        S_SH_RD: begin
          if (idx < AW'(count)) begin
            state <= S_SH_WR;
          end else begin
            count <= count - CW'(1);
            state <= S_H_START;
          end
        end
        S_SH_WR: begin
          idx   <= idx + AW'(1);
          state <= S_SH_RD;
        end
        S_CLR: begin
          if (idx == LastAddr) begin
            count <= '0;
            state <= S_H_START;
          end else begin
            idx <= idx + AW'(1);
          end
        end
        S_H_START: begin
          h     <= 32'd1;
          idx   <= '0;
          state <= S_H_MUL;
        end
        S_H_MUL: begin
          prod  <= 64'(h ^ rdata) * 64'(scpt_pkg::HashMul);
          state <= S_H_FOLD;
        end
        S_H_FOLD: begin
          h <= fold;
          if (idx == LastAddr) begin
            csum <= fold;
            // Every pass started by a request follows a successful change.
            if (emit) begin
              res_status <= scpt_pkg::StatOk;
              state      <= S_DONE;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            idx   <= idx + AW'(1);
            state <= S_H_MUL;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= res_status;
            m_tdata  <= {6'd0, csum, count, res_target};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `SCPT_ASSERT_SAME(a_count_max, clk, rst, 1'b1, count <= CW'(MAX_CUE_POINTS), "count over limit")
  `SCPT_ASSERT_NEXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready, "ready after accept")
  `SCPT_ASSERT_SAME(a_no_write_idle, clk, rst, state == S_IDLE, !mem_we, "table written while idle")

endmodule

### dv/scpt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cue point table checker
// Watches the request, result and register write channels, keeps its own copy
// of the sorted table and queues one expected result per accepted request.
// Each result beat is compared field by field with the oldest expectation.
// ----------------------------------------------------------------------------
module scpt_checker #(
  parameter int MaxCue = scpt_pkg::MaxCuePoints
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] position
  input  logic [2:0]  s_tuser,   // [2:0] action
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [79:0] m_tdata,   // [31:0] target, [41:32] count, [73:42] checksum
  input  logic [1:0]  m_tuser,   // [1:0] status
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic        cfg_data,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] target;
    logic [9:0]  count;
    logic [31:0] checksum;
  } cue_result_t;

  logic [31:0] cues [1:scpt_pkg::TableSlots];
  int          cue_cnt;
  logic [31:0] cue_sum;
  logic        wr_en;
  logic        tbl_ok;
  cue_result_t awaited_results [$];

  function automatic logic [31:0] slot(int s);
    if (s < 1 || s > scpt_pkg::TableSlots) return scpt_pkg::EmptySlot;
    return cues[s];
  endfunction

  function automatic logic [31:0] table_sum();
    logic [31:0] h;
    logic [63:0] p;
    h = 32'd1;
    for (int i = 1; i <= scpt_pkg::TableSlots; i++) begin
      h = h ^ cues[i];
      p = {32'd0, h} * {32'd0, scpt_pkg::HashMul};
      h = p[31:0] ^ p[63:32];
    end
    return h;
  endfunction

  // Slot that holds pos, or the last slot below it, never less than one.
  function automatic int find_slot(logic [31:0] pos);
    int lo, hi, mid;
    lo = 1;
    hi = cue_cnt + 1;
    while (lo + 1 < hi) begin
      mid = (lo + hi) >> 1;
      if (pos > slot(mid)) lo = mid;
      else if (pos < slot(mid)) hi = mid;
      else return mid;
    end
    return lo;
  endfunction

  function automatic void drop_nearest(logic [31:0] pos);
    int pick;
    logic [31:0] best, v, d;
    bit have;
    pick = 1;
    best = '0;
    have = 0;
    for (int i = 1; i <= cue_cnt; i++) begin
      v = slot(i);
      d = (v >= pos) ? v - pos : pos - v;
      if (have && d >= best) break;
      best = d;
      have = 1;
      pick = i;
    end
    for (int i = pick; i < cue_cnt; i++) cues[i] = cues[i + 1];
    cues[cue_cnt] = scpt_pkg::FreedSlot;
    cue_cnt--;
    cue_sum = table_sum();
  endfunction

  function automatic cue_result_t apply_request(logic [2:0] act, logic [31:0] raw);
    cue_result_t r;
    logic [31:0] pos, a, v;
    int n;
    pos = (raw < scpt_pkg::PosClamp) ? raw : scpt_pkg::PosClamp;
    r.status = scpt_pkg::StatRefused;
    r.target = '0;
    case (act)
      scpt_pkg::ActAdd: begin
        if (wr_en && tbl_ok && cue_cnt < MaxCue &&
            !(cue_cnt > 0 && slot(find_slot(pos)) == pos)) begin
          cue_cnt++;
          cues[cue_cnt] = pos;
          for (int i = cue_cnt - 1; i >= 1; i--) begin
            if (cues[i] < cues[i + 1]) break;
            a = cues[i];
            cues[i] = cues[i + 1];
            cues[i + 1] = a;
          end
          cue_sum = table_sum();
          r.status = scpt_pkg::StatOk;
        end
      end
      scpt_pkg::ActDelNear: begin
        if (wr_en && cue_cnt > 0) begin
          drop_nearest(pos);
          r.status = scpt_pkg::StatOk;
        end
      end
      scpt_pkg::ActDelExact: begin
        if (wr_en && cue_cnt > 0 && slot(find_slot(pos)) == pos) begin
          drop_nearest(pos);
          r.status = scpt_pkg::StatOk;
        end
      end
      scpt_pkg::ActClear: begin
        if (wr_en && cue_cnt > 0) begin
          for (int i = 1; i <= scpt_pkg::TableSlots; i++) cues[i] = scpt_pkg::EmptySlot;
          cue_cnt = 0;
          cue_sum = table_sum();
          r.status = scpt_pkg::StatOk;
        end
      end
      scpt_pkg::ActSeekFwd, scpt_pkg::ActSeekBwd: begin
        r.status = scpt_pkg::StatNone;
        if (cue_cnt > 0) begin
          n = find_slot(pos);
          v = slot(n);
          if ((act == scpt_pkg::ActSeekBwd && v < pos) ||
              (act == scpt_pkg::ActSeekFwd && v > pos)) begin
            r.target = v;
            r.status = scpt_pkg::StatOk;
          end else if (act == scpt_pkg::ActSeekBwd && n > 1) begin
            r.target = slot(n - 1);
            r.status = scpt_pkg::StatOk;
          end else if (act == scpt_pkg::ActSeekFwd && n < cue_cnt) begin
            r.target = slot(n + 1);
            r.status = scpt_pkg::StatOk;
          end
        end
      end
      default: ;
    endcase
    r.count = cue_cnt[9:0];
    r.checksum = cue_sum;
    return r;
  endfunction

  always @(posedge clk) begin
    cue_result_t want, got;
    if (rst) begin
      for (int i = 1; i <= scpt_pkg::TableSlots; i++) cues[i] = scpt_pkg::EmptySlot;
      cue_cnt = 0;
      cue_sum = table_sum();
      wr_en = 0;
      tbl_ok = 0;
      awaited_results.delete();
      errors = 0;
      pending = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == scpt_pkg::RegWriteEnable) wr_en = cfg_data;
        else tbl_ok = cfg_data;
      end
      if (s_tvalid && s_tready)
        awaited_results.push_back(apply_request(s_tuser, s_tdata));
      if (m_tvalid && m_tready) begin
        got = {m_tuser, m_tdata[31:0], m_tdata[41:32], m_tdata[73:42]};
        if (awaited_results.size() == 0) begin
          errors++;
          if (errors <= 10) $display("result beat with nothing awaited: %p", got);
        end else begin
          want = awaited_results.pop_front();
          if (got != want || m_tdata[79:74] != '0) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected %p, got %p, pad %h", want, got,
                       m_tdata[79:74]);
          end
        end
      end
      pending = awaited_results.size();
    end
  end

endmodule

### dv/tb_sorted_cue_point_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cue point table unit testbench
// Directed requests cover empty, read-only and extreme-position cases; random
// requests, with positions partly from a small pool, exercise add, delete, clear,
// seek and unused actions under changing register settings and handshake idling.
// ----------------------------------------------------------------------------
module tb_sorted_cue_point_table_unit;

  localparam int StallLimit = 40000;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // [31:0] position
  logic [2:0]  s_tuser;   // [2:0] action
  logic        m_tvalid;
  logic        m_tready;
  logic [79:0] m_tdata;   // [31:0] target, [41:32] count, [73:42] checksum
  logic [1:0]  m_tuser;   // [1:0] status
  logic        cfg_we;
  logic        cfg_index;
  logic        cfg_data;
  int          errors;
  int          pending;
  int          tx_idle_pct;
  int          rx_idle_pct;
  int          quiet_cycles;
  logic [31:0] pos_pool [16];

  sorted_cue_point_table_unit dut (.*);

  scpt_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Leaves tvalid high after the accepting edge so the next call can follow
  // without lowering and raising it in the same step.
  task automatic send_req(input logic [2:0] act, input logic [31:0] pos);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= pos;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic settle_and_config(input logic we, input logic tp);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= scpt_pkg::RegWriteEnable;
    cfg_data  <= we;
    @(posedge clk);
    cfg_index <= scpt_pkg::RegTablePresent;
    cfg_data  <= tp;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_req();
    int sel;
    logic [2:0] act;
    logic [31:0] pos;
    sel = $urandom_range(99);
    if (sel < 36) act = scpt_pkg::ActAdd;
    else if (sel < 48) act = scpt_pkg::ActDelNear;
    else if (sel < 62) act = scpt_pkg::ActDelExact;
    else if (sel < 66) act = scpt_pkg::ActClear;
    else if (sel < 81) act = scpt_pkg::ActSeekFwd;
    else if (sel < 96) act = scpt_pkg::ActSeekBwd;
    else act = 3'($urandom_range(7, 6));
    pos = ($urandom_range(1) == 0) ? pos_pool[$urandom_range(15)] : $urandom;
    send_req(act, pos);
  endtask

  initial begin
    rst = 1;
    s_tvalid = 0;
    s_tdata = '0;
    s_tuser = '0;
    cfg_we = 0;
    cfg_index = 0;
    cfg_data = 0;
    tx_idle_pct = 14;
    rx_idle_pct = 64;
    for (int i = 0; i < 16; i++) pos_pool[i] = $urandom;
    pos_pool[0] = 32'h0;
    pos_pool[1] = 32'hFFFF_FFFF;
    pos_pool[2] = 32'hFFFF_FFFE;
    pos_pool[3] = 32'hFFFF_FFFD;
    repeat (10) @(posedge clk);
    rst <= 0;

    // Read-only tape with no table: every change is refused, seeks find nothing.
    settle_and_config(1'b0, 1'b0);
    send_req(scpt_pkg::ActAdd, 32'd5);
    send_req(scpt_pkg::ActDelNear, 32'd5);
    send_req(scpt_pkg::ActClear, 32'd0);
    send_req(scpt_pkg::ActSeekFwd, 32'd0);
    send_req(scpt_pkg::ActSeekBwd, 32'hFFFF_FFFF);
    send_req(3'd6, 32'd1);
    send_req(3'd7, 32'd1);
    // Writable but no table: adding is refused; empty deletes and clear too.
    settle_and_config(1'b1, 1'b0);
    send_req(scpt_pkg::ActAdd, 32'd5);
    send_req(scpt_pkg::ActDelExact, 32'd5);
    send_req(scpt_pkg::ActClear, 32'd0);
    settle_and_config(1'b1, 1'b1);
    send_req(scpt_pkg::ActAdd, 32'hFFFF_FFFF);   // clamps to the top position
    send_req(scpt_pkg::ActAdd, 32'hFFFF_FFFE);   // duplicate after clamping
    send_req(scpt_pkg::ActAdd, 32'd0);
    send_req(scpt_pkg::ActAdd, 32'd100);
    send_req(scpt_pkg::ActAdd, 32'd200);
    send_req(scpt_pkg::ActSeekFwd, 32'd100);
    send_req(scpt_pkg::ActSeekBwd, 32'd0);
    send_req(scpt_pkg::ActSeekFwd, 32'hFFFF_FFFF);
    send_req(scpt_pkg::ActDelNear, 32'd150);     // tie: the lower entry goes
    send_req(scpt_pkg::ActDelExact, 32'd150);    // no exact match
    for (int i = 1; i <= 6; i++) send_req(scpt_pkg::ActAdd, 32'(i * 1000));
    send_req(scpt_pkg::ActDelExact, 32'd3000);
    send_req(scpt_pkg::ActClear, 32'd0);

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 14 : (ph == 1) ? 64 : 0;
      rx_idle_pct = (ph == 0) ? 64 : (ph == 1) ? 14 : 0;
      for (int blk = 0; blk < 6; blk++) begin
        if (blk == 5) settle_and_config(1'($urandom_range(1)), 1'($urandom_range(1)));
        else settle_and_config(1'b1, 1'b1);
        repeat (30) random_req();
      end
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule

### sorted_cue_point_table_unit.f
+incdir+hdl
hdl/scpt_pkg.sv
hdl/sorted_cue_point_table_unit.sv
dv/scpt_checker.sv
dv/tb_sorted_cue_point_table_unit.sv
